// ===== rtl/bpr_pkg.sv =====
// Shared types and constants for the block pixelate reducer.
`timescale 1ns / 1ps
`default_nettype none
package bpr_pkg;
  localparam int unsigned DEF_MAX_LINE_WIDTH = 4096;
  localparam int unsigned DEF_SAMPLE_BITS    = 16;
  localparam int unsigned DEF_MAX_BLOCK      = 1024;

  localparam int unsigned ACC_W   = 36;
  localparam int unsigned CNT_W   = 21;
  localparam int unsigned PIX_W   = 16;
  localparam int unsigned POS_W   = 12;
  localparam int unsigned CIDX_W  = 3;
  localparam int unsigned CDATA_W = 13;

  localparam logic [1:0] MODE_MIN = 2'd1;
  localparam logic [1:0] MODE_MAX = 2'd2;

  localparam logic [CIDX_W-1:0] REG_BLOCK_WIDTH  = 3'd0;
  localparam logic [CIDX_W-1:0] REG_BLOCK_HEIGHT = 3'd1;
  localparam logic [CIDX_W-1:0] REG_MODE         = 3'd2;
  localparam logic [CIDX_W-1:0] REG_PLANE_WIDTH  = 3'd3;
  localparam logic [CIDX_W-1:0] REG_PLANE_HEIGHT = 3'd4;

  localparam logic [15:0] PLANE_HEIGHT_MAX = 16'd4096;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_PUSH
  } state_e;
endpackage
`default_nettype wire

// ===== rtl/bpr_acc_mem.sv =====
// Per-block-column accumulator memory with a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module bpr_acc_mem #(
  parameter int unsigned DEPTH  = bpr_pkg::DEF_MAX_LINE_WIDTH,
  parameter int unsigned DATA_W = bpr_pkg::ACC_W
) (
  input  wire logic                     clk_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [DATA_W-1:0]        rd_data_o,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [DATA_W-1:0]        wr_data_i
);
  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;
endmodule
`default_nettype wire

// ===== rtl/bpr_divider.sv =====
// Restoring divider that retires one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module bpr_divider (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [bpr_pkg::ACC_W-1:0]  dividend_i,
  input  wire logic [bpr_pkg::CNT_W-1:0]  divisor_i,
  output logic                            done_o,
  output logic [bpr_pkg::ACC_W-1:0]       quotient_o
);
  import bpr_pkg::*;

  localparam int unsigned STEP_W = $clog2(ACC_W + 1);

  logic [ACC_W-1:0]  quo_q, quo_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [CNT_W-1:0]  dvs_q;
  logic [STEP_W-1:0] step_q, step_d;
  logic              done_q, done_d;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;

  always_comb begin
    trial  = {rem_q, quo_q[ACC_W-1]};
    diff   = trial - {1'b0, dvs_q};
    quo_d  = quo_q;
    rem_d  = rem_q;
    step_d = step_q;
    done_d = 1'b0;
    if (step_q != '0) begin
      if (!diff[CNT_W]) begin
        rem_d = diff[CNT_W-1:0];
        quo_d = {quo_q[ACC_W-2:0], 1'b1};
      end else begin
        rem_d = trial[CNT_W-1:0];
        quo_d = {quo_q[ACC_W-2:0], 1'b0};
      end
      step_d = step_q - 1'b1;
      done_d = (step_q == STEP_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      step_q <= STEP_W'(ACC_W);
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> step_q == '0) else $error("divider restarted while busy");
  a_done_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == STEP_W'(1) && !start_i) |=> done_q) else $error("missing done");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> step_q == '0) else $error("done while busy");
endmodule
`default_nettype wire

// ===== rtl/block_pixelate_reduce.sv =====
// Block pixelate reducer: per-block average, minimum or maximum of a raster plane.
// Each pixel is accepted with its memory read, then modified and written back.
// A block end adds a push step for minimum and maximum, and the divider run plus
// the push for the average.
// The result sits in an output register, so the next pixel is taken while it waits.
// Reset returns the position counters and configuration registers to defaults; the
// accumulator memory is not cleared, since each block's first pixel writes it.
`timescale 1ns / 1ps
`default_nettype none
module block_pixelate_reduce #(
  parameter int unsigned MAX_LINE_WIDTH = bpr_pkg::DEF_MAX_LINE_WIDTH,
  parameter int unsigned SAMPLE_BITS    = bpr_pkg::DEF_SAMPLE_BITS,
  parameter int unsigned MAX_BLOCK      = bpr_pkg::DEF_MAX_BLOCK
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [bpr_pkg::PIX_W-1:0]     pixel_value_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic      [bpr_pkg::PIX_W-1:0]     fill_value_o,
  output logic      [bpr_pkg::POS_W-1:0]     block_column_o,
  output logic      [bpr_pkg::POS_W-1:0]     block_row_o,
  output logic                               last_of_frame_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [bpr_pkg::CIDX_W-1:0]    cfg_index_i,
  input  wire logic [bpr_pkg::CDATA_W-1:0]   cfg_data_i
);
  import bpr_pkg::*;

  localparam int unsigned XW = $clog2(MAX_LINE_WIDTH);
  localparam int unsigned XB = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
  localparam logic [15:0] MLW = 16'(MAX_LINE_WIDTH);
  localparam logic [10:0] MBK = 11'(MAX_BLOCK);

  // Configuration registers.
  logic [10:0] bw_reg_q, bh_reg_q;
  logic [1:0]  mode_q;
  logic [12:0] pw_reg_q, ph_reg_q;
  logic        cfg_wr, cfg_hit;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i;
  always_comb begin
    unique case (cfg_index_i)
      REG_BLOCK_WIDTH, REG_BLOCK_HEIGHT, REG_MODE, REG_PLANE_WIDTH,
      REG_PLANE_HEIGHT: cfg_hit = 1'b1;
      default:          cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bw_reg_q <= 11'd16;
      bh_reg_q <= 11'd16;
      mode_q   <= 2'd0;
      pw_reg_q <= 13'd1920;
      ph_reg_q <= 13'd1080;
    end else if (cfg_wr) begin
      unique case (cfg_index_i)
        REG_BLOCK_WIDTH:  bw_reg_q <= cfg_data_i[10:0];
        REG_BLOCK_HEIGHT: bh_reg_q <= cfg_data_i[10:0];
        REG_MODE:         mode_q   <= cfg_data_i[1:0];
        REG_PLANE_WIDTH:  pw_reg_q <= cfg_data_i;
        REG_PLANE_HEIGHT: ph_reg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamped sizes.
  logic [10:0] bw, bh;
  logic [15:0] pw, ph;
  always_comb begin
    bw = (bw_reg_q == '0) ? 11'd1 : ((bw_reg_q > MBK) ? MBK : bw_reg_q);
    bh = (bh_reg_q == '0) ? 11'd1 : ((bh_reg_q > MBK) ? MBK : bh_reg_q);
    pw = (pw_reg_q == '0) ? 16'd1 :
         ((16'(pw_reg_q) > MLW) ? MLW : 16'(pw_reg_q));
    ph = (ph_reg_q == '0) ? 16'd1 :
         ((16'(ph_reg_q) > PLANE_HEIGHT_MAX) ? PLANE_HEIGHT_MAX : 16'(ph_reg_q));
  end

  // Position counters.
  logic [XW-1:0]    px_q, px_d, bx_q, bx_d;
  logic [POS_W-1:0] py_q, py_d, by_q, by_d;
  logic [XB-1:0]    xib_q, xib_d, yib_q, yib_d;
  logic line_end, frame_end, col_end, row_end, py_last;
  logic [10:0] xcnt, ycnt;

  state_e state_q, state_d;
  logic   in_acc;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    xcnt      = 11'(xib_q) + 11'd1;
    ycnt      = 11'(yib_q) + 11'd1;
    line_end  = (16'(px_q) + 16'd1) >= pw;
    py_last   = (16'(py_q) + 16'd1) >= ph;
    frame_end = line_end && py_last;
    col_end   = line_end || (xcnt >= bw);
    row_end   = py_last || (ycnt >= bh);
    px_d = px_q; bx_d = bx_q; py_d = py_q; by_d = by_q;
    xib_d = xib_q; yib_d = yib_q;
    if (frame_end) begin
      px_d = '0; bx_d = '0; py_d = '0; by_d = '0; xib_d = '0; yib_d = '0;
    end else if (line_end) begin
      px_d = '0; bx_d = '0; xib_d = '0;
      py_d = py_q + 1'b1;
      if (row_end) begin
        yib_d = '0;
        by_d  = by_q + 1'b1;
      end else begin
        yib_d = yib_q + 1'b1;
      end
    end else if (col_end) begin
      px_d = px_q + 1'b1; xib_d = '0; bx_d = bx_q + 1'b1;
    end else begin
      px_d = px_q + 1'b1; xib_d = xib_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      px_q <= '0; bx_q <= '0; py_q <= '0; by_q <= '0; xib_q <= '0; yib_q <= '0;
    end else if (cfg_wr && cfg_hit) begin
      px_q <= '0; bx_q <= '0; py_q <= '0; by_q <= '0; xib_q <= '0; yib_q <= '0;
    end else if (in_acc) begin
      px_q <= px_d; bx_q <= bx_d; py_q <= py_d; by_q <= by_d;
      xib_q <= xib_d; yib_q <= yib_d;
    end
  end

  // Per-pixel work registers, captured on the input transfer.
  logic [ACC_W-1:0] v_q;
  logic             first_q, emit_q, fend_q;
  logic [XW-1:0]    idx_q;
  logic [POS_W-1:0] bcol_q, brow_q;
  logic [CNT_W-1:0] count_q;
  logic [21:0]      prod;

  assign prod = 22'(xcnt) * 22'(ycnt);

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      v_q     <= ACC_W'(pixel_value_i[SAMPLE_BITS-1:0]);
      first_q <= (xib_q == '0) && (yib_q == '0);
      emit_q  <= col_end && row_end;
      fend_q  <= frame_end;
      idx_q   <= bx_q;
      bcol_q  <= POS_W'(bx_q);
      brow_q  <= by_q;
      count_q <= prod[CNT_W-1:0];
    end
  end

  // Accumulator memory read-modify-write.
  logic [ACC_W-1:0] rd_data, acc_new;
  logic             wr_en;

  bpr_acc_mem #(
    .DEPTH  (MAX_LINE_WIDTH),
    .DATA_W (ACC_W)
  ) u_mem (
    .clk_i     (clk_i),
    .rd_en_i   (in_acc),
    .rd_addr_i (bx_q),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (idx_q),
    .wr_data_i (acc_new)
  );

  always_comb begin
    if (first_q) begin
      acc_new = v_q;
    end else begin
      case (mode_q)
        MODE_MIN: acc_new = (v_q < rd_data) ? v_q : rd_data;
        MODE_MAX: acc_new = (v_q > rd_data) ? v_q : rd_data;
        default:  acc_new = rd_data + v_q;
      endcase
    end
  end

  logic is_avg, div_start, div_done;
  logic [ACC_W-1:0] quotient;

  assign wr_en     = (state_q == ST_READ);
  assign is_avg    = (mode_q != MODE_MIN) && (mode_q != MODE_MAX);
  assign div_start = wr_en && emit_q && is_avg;

  bpr_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (acc_new),
    .divisor_i  (count_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Sequencer and output register.
  logic [PIX_W-1:0] fill_q;
  logic             out_valid_q, out_free, push;
  logic [PIX_W-1:0] fill_out_q;
  logic [POS_W-1:0] col_out_q, row_out_q;
  logic             last_out_q;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    push    = 1'b0;
    unique case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_READ;
      ST_READ: begin
        if (!emit_q)     state_d = ST_IDLE;
        else if (is_avg) state_d = ST_DIV;
        else             state_d = ST_PUSH;
      end
      ST_DIV:  if (div_done) state_d = ST_PUSH;
      ST_PUSH: begin
        if (out_free) begin
          push    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (push)            out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_READ) begin
      fill_q <= PIX_W'(acc_new);
    end else if (state_q == ST_DIV && div_done) begin
      fill_q <= quotient[PIX_W-1:0];
    end
    if (push) begin
      fill_out_q <= fill_q;
      col_out_q  <= bcol_q;
      row_out_q  <= brow_q;
      last_out_q <= fend_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign fill_value_o    = fill_out_q;
  assign block_column_o  = col_out_q;
  assign block_row_o     = row_out_q;
  assign last_of_frame_o = last_out_q;

  a_accept_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == ST_READ) else $error("accepted pixel not read");
  a_result_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> out_valid_q) else $error("result dropped");
  a_div_avg_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> (emit_q && is_avg)) else $error("divider started without need");
  a_push_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> $past(state_q) != ST_IDLE) else $error("push from idle");
endmodule
`default_nettype wire
